// ===== sv/ssm_pkg.sv =====
// Shared types and constants for the signature substring matcher.
// Holds the signature table, the case-fold function and the step control struct.
// No dependencies.
package ssm_pkg;

    localparam int unsigned WIN_DEPTH = 11;
    localparam int unsigned CMP_BYTES = WIN_DEPTH + 1;
    localparam int unsigned SIG_COUNT = 5;
    localparam int unsigned SIG_LEN_W = 4;

    // Signatures in lower case, right-justified: the final character sits in byte 0,
    // so byte k lines up with the byte seen k steps before the current one.
    localparam logic [CMP_BYTES*8-1:0] SIG_TEXT [SIG_COUNT] = '{
        96'("<script>"),
        96'("../"),
        96'("or 1=1"),
        96'("admin"),
        96'("union select")
    };

    localparam logic [SIG_LEN_W-1:0] SIG_LEN [SIG_COUNT] = '{
        4'd8, 4'd3, 4'd6, 4'd5, 4'd12
    };

    // Control that goes with the byte being scanned.
    typedef struct packed {
        logic en;    // a byte is scanned in this cycle
        logic last;  // it is the last byte of its chunk
    } t_step;

    // Only the ASCII capitals fold; every other code passes unchanged.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== sv/signature_substring_matcher_top.sv =====
// A chunk's verdict is registered in the output stage as its last byte is processed.
// One byte per cycle unless a last byte meets a full output; compare logic is combinational.
// The input stage keeps taking bytes while a verdict waits, until a chunk's last byte stalls.
// Reset (i_rst_n low, synchronous) empties both stages and clears the byte window.
// Top level of the signature substring matcher; depends on ssm_pkg and ssm_scan.
module signature_substring_matcher_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // chunk_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] malicious, [7:1] zero
);
    import ssm_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    logic       r_out_hit;

    logic  proc;
    logic  hit;
    t_step step;

    // A registered byte moves on unless it would produce a verdict into a full output.
    assign proc          = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc;

    assign step.en   = proc;
    assign step.last = r_in_last;

    ssm_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_hit   (hit)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Output register holding one verdict.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_last) begin
            r_out_hit <= hit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_hit};

`ifndef SYNTHESIS
    // A chunk's last byte always leaves a verdict in the output register.
    a_last_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_last |=> r_out_valid)
        else $error("last byte processed without a verdict");

    // The input stage never takes a byte while its held byte stays put.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !proc |-> !s_axis_tready)
        else $error("input register overwritten");

    // A waiting verdict blocks the next chunk end from being processed.
    a_verdict_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready && r_in_valid && r_in_last |-> !proc)
        else $error("pending verdict would be overwritten");
`endif

endmodule

// ===== sv/ssm_scan.sv =====
// Window of recent bytes and the parallel signature compare for one chunk.
// Depends on ssm_pkg.
module ssm_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ssm_pkg::t_step i_step,
    input  logic [7:0]    i_byte,
    output logic          o_hit
);
    import ssm_pkg::*;

    logic [7:0] r_win [WIN_DEPTH];
    logic [7:0] n_win [WIN_DEPTH];
    logic       r_zero_seen;
    logic       n_zero_seen;
    logic       r_hit_seen;
    logic       n_hit_seen;

    logic [7:0]             cur;
    logic [CMP_BYTES*8-1:0] cmp_bytes;
    logic [SIG_COUNT-1:0]   sig_hit;
    logic                   live;

    // A byte takes part only before any zero byte of the chunk, and never as zero itself.
    assign cur  = fold_case(i_byte);
    assign live = !r_zero_seen && (i_byte != 8'h00);

    // Current byte in byte 0, then the window newest first.
    always_comb begin
        cmp_bytes[7:0] = cur;
        for (int k = 0; k < WIN_DEPTH; k++) begin
            cmp_bytes[(k+1)*8 +: 8] = r_win[k];
        end
    end

    // Each signature compares its own length of bytes in parallel.
    always_comb begin
        for (int s = 0; s < SIG_COUNT; s++) begin
            sig_hit[s] = 1'b1;
            for (int i = 0; i < CMP_BYTES; i++) begin
                if (i < int'(SIG_LEN[s]) &&
                    cmp_bytes[i*8 +: 8] != SIG_TEXT[s][i*8 +: 8]) begin
                    sig_hit[s] = 1'b0;
                end
            end
        end
    end

    // The verdict for this byte covers every earlier match in the chunk.
    assign o_hit = r_hit_seen || (live && (|sig_hit));

    // Next state: shift the window on live bytes, clear everything at the chunk end.
    always_comb begin
        n_win       = r_win;
        n_zero_seen = r_zero_seen;
        n_hit_seen  = r_hit_seen;
        if (i_step.en) begin
            if (i_step.last) begin
                for (int k = 0; k < WIN_DEPTH; k++) begin
                    n_win[k] = 8'h00;
                end
                n_zero_seen = 1'b0;
                n_hit_seen  = 1'b0;
            end else if (!r_zero_seen) begin
                if (i_byte == 8'h00) begin
                    n_zero_seen = 1'b1;
                end else begin
                    n_hit_seen = o_hit;
                    for (int k = 1; k < WIN_DEPTH; k++) begin
                        n_win[k] = r_win[k-1];
                    end
                    n_win[0] = cur;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
                r_win[k] <= 8'h00;
            end
            r_zero_seen <= 1'b0;
            r_hit_seen  <= 1'b0;
        end else begin
            r_win       <= n_win;
            r_zero_seen <= n_zero_seen;
            r_hit_seen  <= n_hit_seen;
        end
    end

endmodule

// ===== tb/sv/signature_substring_matcher_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for signature_substring_matcher_top.
// Streams request chunks byte by byte and checks every per-chunk verdict against a local
// predictor of the case-insensitive signature search; needs only the RTL under sv/.
module signature_substring_matcher_top_tb;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    localparam int HIST_DEPTH   = 11;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 1400;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic       s_axis_tlast = 1'b0;    // chunk_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [0] malicious, [7:1] zero

    // Signatures in lower case; input letters are folded before the compare.
    string sig_list [5] = '{"<script>", "../", "or 1=1", "admin", "union select"};
    string noise_chars = "<>/.= 1scriptoradmunel";

    // Predictor state: folded recent bytes (newest first) and per-chunk flags.
    logic [7:0] recent [HIST_DEPTH];
    bit         zero_cut;
    bit         sig_found;

    logic       expected_verdicts [$];
    logic [7:0] chunk_buf [$];
    logic       expected_verdict;
    int         mismatch_count = 0;
    int         bytes_sent = 0;
    int         burst_left = 0;
    bit         tx_bursty = 1'b0;
    bit         hold_req = 1'b0;
    t_rx_mode   rx_mode = RX_ALWAYS;

    signature_substring_matcher_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Clear the per-chunk search state.
    function automatic void clear_search();
        for (int k = 0; k < HIST_DEPTH; k++) begin
            recent[k] = 8'h00;
        end
        zero_cut  = 1'b0;
        sig_found = 1'b0;
    endfunction

    // Only ASCII capitals fold to lower case.
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // True when signature s ends at the folded byte cur.
    function automatic bit sig_ends_at(input int s, input logic [7:0] cur);
        int         len;
        logic [7:0] ch;
        len = sig_list[s].len();
        ch  = sig_list[s][len-1];
        if (cur != ch) begin
            return 1'b0;
        end
        for (int k = 0; k + 1 < len; k++) begin
            ch = sig_list[s][len-2-k];
            if (recent[k] != ch) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Advance the search by one byte; returns 1 with the verdict at the chunk's last byte.
    function automatic bit predict_verdict(input logic [7:0] b, input logic last,
                                           output logic verdict);
        logic [7:0] cur;
        verdict = 1'b0;
        if (!zero_cut) begin
            if (b == 8'h00) begin
                zero_cut = 1'b1;
            end else begin
                cur = to_lower(b);
                for (int s = 0; s < 5; s++) begin
                    if (sig_ends_at(s, cur)) begin
                        sig_found = 1'b1;
                    end
                end
                for (int k = HIST_DEPTH - 1; k > 0; k--) begin
                    recent[k] = recent[k-1];
                end
                recent[0] = cur;
            end
        end
        if (!last) begin
            return 1'b0;
        end
        verdict = sig_found;
        clear_search();
        return 1'b1;
    endfunction

    // Randomly raise a lower-case letter.
    function automatic logic [7:0] vary_case(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1) == 1) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    // Background byte: mostly signature letters, some arbitrary codes, rare zeros.
    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(99);
        if (r < 2) begin
            return 8'h00;
        end else if (r < 30) begin
            return 8'($urandom_range(255));
        end
        return vary_case(noise_chars[$urandom_range(noise_chars.len() - 1)]);
    endfunction

    // Offer one byte, wait for its transfer, record the prediction, then maybe idle.
    // Called and returns at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        logic v;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (predict_verdict(b, last, v)) begin
            expected_verdicts.push_back(v);
        end
        bytes_sent++;
        @(negedge i_clk);
        if (tx_bursty) begin
            if (burst_left == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_text(input string t, input bit ends);
        for (int i = 0; i < t.len(); i++) begin
            send_byte(t[i], ends && (i == t.len() - 1));
        end
    endtask

    // Fill chunk_buf with noise, often with a signature planted, sometimes with one byte spoiled.
    task automatic build_chunk();
        int         len;
        int         pos;
        int         spoil;
        string      sig;
        logic [7:0] c;
        chunk_buf.delete();
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 16);
        for (int i = 0; i < len; i++) begin
            chunk_buf.push_back(noise_byte());
        end
        if ($urandom_range(99) < 60) begin
            sig   = sig_list[$urandom_range(4)];
            pos   = $urandom_range(chunk_buf.size());
            spoil = ($urandom_range(3) == 0) ? $urandom_range(sig.len() - 1) : -1;
            for (int i = 0; i < sig.len(); i++) begin
                c = vary_case(sig[i]);
                if (i == spoil) begin
                    c = c ^ 8'h01;
                end
                chunk_buf.insert(pos + i, c);
            end
        end
    endtask

    task automatic send_chunk();
        for (int i = 0; i < chunk_buf.size(); i++) begin
            send_byte(chunk_buf[i], i == chunk_buf.size() - 1);
        end
    endtask

    // Field extremes, zero-byte cutoff, chunk boundaries and non-ASCII bytes.
    task automatic test_directed();
        tx_bursty = 1'b0;
        rx_mode   = RX_ALWAYS;
        send_byte(8'h00, 1'b1);            // lone zero byte
        send_byte(8'hFF, 1'b1);            // lone top code
        send_text("ADMIN", 1'b0);          // match before a zero still counts
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);            // zero ends matching for the rest of the chunk
        send_text("../", 1'b1);
        send_text("..", 1'b1);             // a match never spans two chunks
        send_text("/", 1'b1);
        send_byte(8'hE1, 1'b0);            // high-bit byte is not folded
        send_text("dmin", 1'b1);
        send_text("x../", 1'b1);
    endtask

    // Random chunks over phases with different sender and receiver idling.
    task automatic test_random_chunks();
        int target;
        for (int phase = 0; phase < 6; phase++) begin
            tx_bursty = (phase % 3) != 0;
            rx_mode   = t_rx_mode'(phase % 4);
            target    = bytes_sent + RANDOM_BYTES / 6;
            while (bytes_sent < target) begin
                build_chunk();
                send_chunk();
            end
        end
    endtask

    // Receiver holds off for a long stretch while short chunks keep coming.
    task automatic test_backpressure();
        tx_bursty = 1'b0;
        rx_mode   = RX_ALWAYS;
        hold_req  = 1'b1;
        for (int i = 0; i < 48; i++) begin
            if (i % 3 == 0) begin
                send_text("../", 1'b1);
            end else begin
                send_byte(8'($urandom_range(255)), 1'b1);
            end
        end
    endtask

    // Receiver ready pattern, with a long hold-off on request.
    initial begin : rx_ready_gen
        int hold_left;
        int pat_cnt;
        hold_left = 0;
        pat_cnt   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req      = 1'b0;
                hold_left     = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: m_axis_tready <= 1'b1;
                    RX_RANDOM: m_axis_tready <= $urandom_range(1);
                    RX_SPARSE: m_axis_tready <= ($urandom_range(7) != 0);
                    default: begin
                        m_axis_tready <= (pat_cnt % 5) < 2;
                        pat_cnt++;
                    end
                endcase
            end
        end
    end

    // Compare each verdict transfer with the oldest expected verdict.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                $error("malicious: unexpected result, actual %0b", m_axis_tdata[0]);
                mismatch_count++;
            end else begin
                expected_verdict = expected_verdicts.pop_front();
                if (m_axis_tdata[0] !== expected_verdict) begin
                    $error("malicious: expected %0b, actual %0b",
                           expected_verdict, m_axis_tdata[0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[7:1] !== 7'd0) begin
                    $error("tdata padding: expected 0, actual %0h", m_axis_tdata[7:1]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : main_seq
        int drain;
        clear_search();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_chunks();
        test_backpressure();
        s_axis_tvalid <= 1'b0;
        rx_mode = RX_RANDOM;
        // Wait for the outstanding verdicts, then keep watching for strays.
        drain = 0;
        while (expected_verdicts.size() != 0 && drain < 2000) begin
            @(posedge i_clk);
            drain++;
        end
        if (expected_verdicts.size() != 0) begin
            $error("malicious: %0d expected results never arrived", expected_verdicts.size());
            mismatch_count++;
        end
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard limit on run time.
    initial begin : watchdog
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
